// ----- src/ple_pkg.sv -----
// Shared constants and codes for the positional list engine.
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 2;
  localparam int DATA_W   = 32;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT    = 3'd0,
    ACT_REMOVE    = 3'd1,
    ACT_READ      = 3'd2,
    ACT_OVERWRITE = 3'd3,
    ACT_FIND      = 3'd4,
    ACT_CLEAR     = 3'd5
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic signed [POS_W-1:0] NOT_FOUND = '1;

endpackage

// ----- src/positional_list_engine_core.sv -----
// Positional list engine: an ordered list of signed words kept in one memory.
//
// The list lives in a single-port-per-direction synchronous memory of CAPACITY
// words (one write and one read per cycle, read data registered) plus an
// element count. Each request transaction does one action: insert at a
// position (later elements move up), remove at a position (later elements
// move down, the removed word is returned), read, overwrite (the old word is
// returned), find the first position holding a value, or clear. Every result
// reports the new length and whether the list is empty. The memory walk moves
// one element per cycle: insert and remove walk the elements from the position
// to the end of the list, and find walks from the start until a hit or the end.
// A new request is taken only once the previous one has finished its walk and
// its result is in the output register, where it may still be waiting; a
// further result is held back until that one is taken. Bad positions report a
// range status and a full list rejects inserts; neither changes the list.
// Clear only zeroes the count, so no clearing pass is needed after reset.
module positional_list_engine_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic        [ple_pkg::ACT_W-1:0]        action,
  input  logic        [ple_pkg::POS_W-1:0]        position,
  input  logic signed [ple_pkg::DATA_W-1:0]       value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic        [ple_pkg::STAT_W-1:0]       status,
  output logic signed [ple_pkg::DATA_W-1:0]       data_out,
  output logic signed [ple_pkg::POS_W-1:0]        found_at,
  output logic        [ple_pkg::POS_W-1:0]        length,
  output logic                                    is_empty
);
  import ple_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_REM_HEAD,
    S_REM_SHIFT,
    S_RD,
    S_OVW,
    S_FIND,
    S_RESP
  } state_t;

  state_t                     state;
  logic [CNT_W-1:0]           count;
  logic [CMP_W-1:0]           pos_r;
  logic [CMP_W-1:0]           idx;
  logic signed [DATA_W-1:0]   val_r;
  logic                       pend;
  logic [ADDR_W-1:0]          pend_addr;
  logic [STAT_W-1:0]          res_status;
  logic signed [DATA_W-1:0]   res_data;
  logic signed [POS_W-1:0]    res_found;

  // Element memory with a registered read port.
  logic [DATA_W-1:0]          mem [CAPACITY];
  logic [DATA_W-1:0]          rd_data;
  logic                       mem_we;
  logic                       mem_re;
  logic [ADDR_W-1:0]          mem_wa;
  logic [ADDR_W-1:0]          mem_ra;
  logic [DATA_W-1:0]          mem_wd;

  logic                       accept;
  logic [CMP_W-1:0]           cnt_x;
  logic [CMP_W-1:0]           pos_x;
  logic [CMP_W-1:0]           idx_dec;
  logic [CMP_W-1:0]           idx_inc;
  logic                       ins_more;
  logic                       rem_more;
  logic                       find_more;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cnt_x     = CMP_W'(count);
  assign pos_x     = CMP_W'(position);
  assign idx_dec   = idx - CMP_W'(1);
  assign idx_inc   = idx + CMP_W'(1);
  // Insert still has elements to move up while the destination is above the
  // insert position; remove while the source is below the old length.
  assign ins_more  = (idx > pos_r);
  assign rem_more  = (idx < cnt_x);
  assign find_more = (idx_inc < cnt_x);

  // Memory port control, decoded from the sequencer state.
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = pend_addr;
    mem_ra = pos_x[ADDR_W-1:0];
    mem_wd = rd_data;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_REMOVE, ACT_READ, ACT_OVERWRITE: begin
              mem_re = (pos_x < cnt_x);
              mem_ra = pos_x[ADDR_W-1:0];
            end
            ACT_FIND: begin
              mem_re = (count != '0);
              mem_ra = '0;
            end
            default: begin
              mem_re = 1'b0;
            end
          endcase
        end
      end
      S_INS: begin
        mem_re = ins_more;
        mem_ra = idx_dec[ADDR_W-1:0];
        if (pend) begin
          mem_we = 1'b1;
          mem_wa = pend_addr;
          mem_wd = rd_data;
        end else if (!ins_more) begin
          mem_we = 1'b1;
          mem_wa = pos_r[ADDR_W-1:0];
          mem_wd = val_r;
        end
      end
      S_REM_SHIFT: begin
        mem_re = rem_more;
        mem_ra = idx[ADDR_W-1:0];
        mem_we = pend;
        mem_wa = pend_addr;
        mem_wd = rd_data;
      end
      S_OVW: begin
        mem_we = 1'b1;
        mem_wa = pos_r[ADDR_W-1:0];
        mem_wd = val_r;
      end
      S_FIND: begin
        mem_re = (rd_data != val_r) && find_more;
        mem_ra = idx_inc[ADDR_W-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pos_r      <= pos_x;
            val_r      <= value;
            pend       <= 1'b0;
            res_status <= ST_OK;
            res_data   <= '0;
            res_found  <= NOT_FOUND;
            state      <= S_RESP;
            case (action)
              ACT_INSERT: begin
                if (pos_x > cnt_x) begin
                  res_status <= ST_RANGE;
                end else if (count == CNT_W'(CAPACITY)) begin
                  res_status <= ST_FULL;
                end else begin
                  idx   <= cnt_x;
                  state <= S_INS;
                end
              end
              ACT_REMOVE, ACT_READ, ACT_OVERWRITE: begin
                if (pos_x >= cnt_x) begin
                  res_status <= ST_RANGE;
                end else if (action == ACT_REMOVE) begin
                  state <= S_REM_HEAD;
                end else if (action == ACT_READ) begin
                  state <= S_RD;
                end else begin
                  state <= S_OVW;
                end
              end
              ACT_FIND: begin
                idx <= '0;
                if (count != '0) begin
                  state <= S_FIND;
                end
              end
              ACT_CLEAR: begin
                count <= '0;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_INS: begin
          // Read idx-1 now, write it to idx on the next cycle.
          pend      <= ins_more;
          pend_addr <= idx[ADDR_W-1:0];
          if (ins_more) begin
            idx <= idx_dec;
          end
          if (!pend && !ins_more) begin
            count <= count + CNT_W'(1);
            state <= S_RESP;
          end
        end
        S_REM_HEAD: begin
          res_data <= rd_data;
          idx      <= pos_r + CMP_W'(1);
          pend     <= 1'b0;
          state    <= S_REM_SHIFT;
        end
        S_REM_SHIFT: begin
          // Read idx now, write it to idx-1 on the next cycle.
          pend      <= rem_more;
          pend_addr <= idx_dec[ADDR_W-1:0];
          if (rem_more) begin
            idx <= idx_inc;
          end
          if (!pend && !rem_more) begin
            count <= count - CNT_W'(1);
            state <= S_RESP;
          end
        end
        S_RD: begin
          res_data <= rd_data;
          state    <= S_RESP;
        end
        S_OVW: begin
          res_data <= rd_data;
          state    <= S_RESP;
        end
        S_FIND: begin
          if (rd_data == val_r) begin
            res_found <= idx[POS_W-1:0];
            state     <= S_RESP;
          end else if (find_more) begin
            idx <= idx_inc;
          end else begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= res_status;
            data_out  <= res_data;
            found_at  <= res_found;
            length    <= cnt_x[POS_W-1:0];
            is_empty  <= (count == '0);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count exceeds capacity");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != S_IDLE))
    else $error("memory written while idle");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("memory read and written at the same entry");

  a_ins_above: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS && pend) |-> (CMP_W'(pend_addr) > pos_r))
    else $error("insert shift writes at or below the insert position");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_CLEAR) |=> (count == '0))
    else $error("clear did not empty the list");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the positional list engine core.
module testbench;
  import ple_pkg::*;

  // The two action codes that the package leaves unnamed must do nothing.
  localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

  localparam int RANDOM_ITEMS = 1950;
  localparam int MAX_GAP      = 16;
  // The longest quiet stretch is a full insert walk plus one gap on each side.
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 100;

  typedef struct {
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    int                       gap;
    bit                       drain;
  } list_request_t;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic signed [POS_W-1:0]  found;
    logic [POS_W-1:0]         length;
    logic                     empty;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [ACT_W-1:0]         action = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] data_out;
  logic signed [POS_W-1:0]  found_at;
  logic [POS_W-1:0]         length;
  logic                     is_empty;

  positional_list_engine_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .data_out  (data_out),
    .found_at  (found_at),
    .length    (length),
    .is_empty  (is_empty)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Requests waiting to be sent, and the results that accepted requests must produce.
  list_request_t pending_requests[$];
  list_result_t  expected_results[$];

  // The list as the block should hold it after every accepted request.
  logic signed [DATA_W-1:0] shadow_mem [CAPACITY];
  int                       shadow_len = 0;

  // Length as the stimulus generator expects it, used to aim positions.
  int                       plan_len = 0;
  int                       planned_items = 0;
  logic signed [DATA_W-1:0] value_pool[$];
  bit                       tx_calm = 1'b0;
  bit                       rx_calm = 1'b0;

  list_request_t tx_req;
  int            tx_wait = 0;
  int            rx_stall = 0;
  int            sent_total = 0;
  int            done_total = 0;
  int            quiet_cycles = 0;
  int            errors = 0;

  int act_count [8];
  int range_count = 0;
  int full_count = 0;
  int hit_count = 0;

  // Works out the result of one accepted request and updates the shadow list.
  task automatic apply_list_op(input list_request_t r);
    list_result_t e;
    int i;
    e.status = ST_OK;
    e.data   = '0;
    e.found  = NOT_FOUND;
    act_count[r.action]++;
    case (r.action)
      ACT_INSERT: begin
        // The range check wins over the full check.
        if (r.position > shadow_len) begin
          e.status = ST_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          e.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > r.position; i--) shadow_mem[i] = shadow_mem[i-1];
          shadow_mem[r.position] = r.value;
          shadow_len++;
        end
      end
      ACT_REMOVE: begin
        if (r.position >= shadow_len) begin
          e.status = ST_RANGE;
        end else begin
          e.data = shadow_mem[r.position];
          for (i = r.position; i + 1 < shadow_len; i++) shadow_mem[i] = shadow_mem[i+1];
          shadow_len--;
        end
      end
      ACT_READ: begin
        if (r.position >= shadow_len) e.status = ST_RANGE;
        else e.data = shadow_mem[r.position];
      end
      ACT_OVERWRITE: begin
        if (r.position >= shadow_len) begin
          e.status = ST_RANGE;
        end else begin
          e.data = shadow_mem[r.position];
          shadow_mem[r.position] = r.value;
        end
      end
      ACT_FIND: begin
        for (i = 0; i < shadow_len && e.found == NOT_FOUND; i++) begin
          if (shadow_mem[i] == r.value) e.found = i[POS_W-1:0];
        end
        if (e.found != NOT_FOUND) hit_count++;
      end
      ACT_CLEAR: begin
        // Stale entries stay in memory but fall outside the list.
        shadow_len = 0;
      end
      default: ;
    endcase
    if (e.status == ST_RANGE) range_count++;
    if (e.status == ST_FULL) full_count++;
    e.length = shadow_len[POS_W-1:0];
    e.empty  = (shadow_len == 0);
    expected_results.push_back(e);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  task automatic check_result();
    list_result_t e;
    if (expected_results.size() == 0) begin
      $display("%0t: result with no request outstanding, expected none, actual status %0h",
               $time, status);
      errors++;
      return;
    end
    e = expected_results.pop_front();
    check_field("status", 32'(e.status), 32'(status));
    check_field("data_out", e.data, data_out);
    check_field("found_at", {25'd0, e.found}, {25'd0, found_at});
    check_field("length", 32'(e.length), 32'(length));
    check_field("is_empty", 32'(e.empty), 32'(is_empty));
  endtask

  // Queues one request and tracks the length the generator believes in.
  task automatic add_request(input logic [ACT_W-1:0] act, input int pos,
                             input logic signed [DATA_W-1:0] val, input bit drain);
    list_request_t r;
    r.action   = act;
    r.position = pos[POS_W-1:0];
    r.value    = val;
    r.gap      = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    r.drain    = drain || ($urandom_range(0, 63) == 0);
    pending_requests.push_back(r);
    planned_items++;
    case (act)
      ACT_INSERT: begin
        if (r.position <= plan_len && plan_len < CAPACITY) plan_len++;
      end
      ACT_REMOVE: begin
        if (r.position < plan_len) plan_len--;
      end
      ACT_CLEAR: plan_len = 0;
      default: ;
    endcase
    if (act == ACT_INSERT || act == ACT_OVERWRITE) begin
      value_pool.push_back(val);
      if (value_pool.size() > 32) void'(value_pool.pop_front());
    end
  endtask

  // Mostly a legal position, sometimes the first illegal one, sometimes anything.
  function automatic int pick_position(input bit for_insert);
    int top;
    int r;
    top = for_insert ? plan_len : plan_len - 1;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, 127);
    if (r < 20 || top < 0) return top + 1;
    return $urandom_range(0, top);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return {1'b0, {31{1'b1}}};
        1: return {1'b1, 31'd0};
        2: return '1;
        default: return '0;
      endcase
    end
    if (r < 3 && value_pool.size() != 0) return value_pool[$urandom_range(0, value_pool.size() - 1)];
    return $urandom();
  endfunction

  // Driver: presents queued requests, honoring each one's gap and drain flag.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_list_op(tx_req);
        sent_total++;
        tx_wait = (pending_requests.size() != 0) ? pending_requests[0].gap : 0;
      end
      if (in_valid && !in_ready) begin
        // The current transaction is still on offer and must not change.
      end else if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].drain && sent_total != done_total)) begin
        tx_req = pending_requests.pop_front();
        action   <= tx_req.action;
        position <= tx_req.position;
        value    <= tx_req.value;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: takes results with random back-pressure and checks each one.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result();
        done_total <= done_total + 1;
        rx_stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a long stretch with no transaction on either side means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int directed_items;
    int kind;
    int r;

    // Directed part: empty-list errors, the value extremes, every action,
    // the unused codes, a drain pause and clear hiding stale entries.
    add_request(ACT_READ, 0, 32'd0, 1'b0);
    add_request(ACT_REMOVE, 0, 32'd0, 1'b0);
    add_request(ACT_OVERWRITE, 0, 32'h1111_1111, 1'b0);
    add_request(ACT_FIND, 0, 32'd5, 1'b0);
    add_request(ACT_INSERT, 1, 32'd7, 1'b0);
    add_request(ACT_INSERT, 127, 32'd7, 1'b0);
    add_request(ACT_INSERT, 0, 32'h7FFF_FFFF, 1'b0);
    add_request(ACT_INSERT, 1, 32'h8000_0000, 1'b0);
    add_request(ACT_INSERT, 0, 32'hFFFF_FFFF, 1'b0);
    add_request(ACT_INSERT, 1, 32'h0000_0000, 1'b0);
    add_request(ACT_READ, 0, 32'd0, 1'b0);
    add_request(ACT_READ, 3, 32'd0, 1'b0);
    add_request(ACT_READ, 4, 32'd0, 1'b0);
    add_request(ACT_OVERWRITE, 2, 32'h5A5A_5A5A, 1'b0);
    add_request(ACT_FIND, 0, 32'h8000_0000, 1'b0);
    add_request(ACT_FIND, 0, 32'h1234_5678, 1'b0);
    add_request(ACT_REMOVE, 1, 32'd0, 1'b0);
    add_request(ACT_REMOVE, 2, 32'd0, 1'b0);
    add_request(ACT_SPARE6, 127, 32'hFFFF_FFFF, 1'b0);
    add_request(ACT_SPARE7, 0, 32'd0, 1'b1);
    add_request(ACT_INSERT, 2, 32'h0000_0001, 1'b0);
    add_request(ACT_CLEAR, 0, 32'd0, 1'b0);
    add_request(ACT_READ, 0, 32'd0, 1'b0);
    add_request(ACT_FIND, 0, 32'h5A5A_5A5A, 1'b0);
    add_request(ACT_INSERT, 0, 32'h0000_0001, 1'b0);
    directed_items = planned_items;

    // Random part, in episodes. It opens with a fill to capacity so the
    // full-list and range-before-full cases are reached early.
    kind = 6;
    while (planned_items < directed_items + RANDOM_ITEMS) begin
      if (kind <= 5) begin
        repeat ($urandom_range(10, 40)) begin
          r = $urandom_range(0, 99);
          if (r < 35) add_request(ACT_INSERT, pick_position(1'b1), pick_value(), 1'b0);
          else if (r < 55) add_request(ACT_REMOVE, pick_position(1'b0), pick_value(), 1'b0);
          else if (r < 68) add_request(ACT_READ, pick_position(1'b0), pick_value(), 1'b0);
          else if (r < 80) add_request(ACT_OVERWRITE, pick_position(1'b0), pick_value(), 1'b0);
          else if (r < 95) add_request(ACT_FIND, $urandom_range(0, 127), pick_value(), 1'b0);
          else if (r < 97) add_request(ACT_CLEAR, $urandom_range(0, 127), $urandom(), 1'b0);
          else add_request(r[0] ? ACT_SPARE6 : ACT_SPARE7, $urandom_range(0, 127), $urandom(), 1'b0);
        end
      end else if (kind == 6) begin
        while (plan_len < CAPACITY) add_request(ACT_INSERT, $urandom_range(0, plan_len), pick_value(), 1'b0);
        add_request(ACT_INSERT, CAPACITY, pick_value(), 1'b0);
        add_request(ACT_INSERT, CAPACITY + 1, pick_value(), 1'b0);
        add_request(ACT_INSERT, $urandom_range(0, CAPACITY - 1), pick_value(), 1'b0);
        add_request(ACT_READ, CAPACITY - 1, 32'd0, 1'b0);
        add_request(ACT_FIND, 0, pick_value(), 1'b0);
      end else if (kind == 7) begin
        while (plan_len > 0) add_request(ACT_REMOVE, $urandom_range(0, plan_len - 1), pick_value(), 1'b0);
        add_request(ACT_READ, 0, 32'd0, 1'b0);
        add_request(ACT_OVERWRITE, 0, pick_value(), 1'b0);
        add_request(ACT_FIND, 0, pick_value(), 1'b0);
      end else if (kind == 8) begin
        // Noise: any code, any position, any value.
        repeat ($urandom_range(5, 15)) begin
          add_request(ACT_W'($urandom_range(0, 7)), $urandom_range(0, 127), $urandom(), 1'b0);
        end
      end else begin
        add_request(ACT_CLEAR, 0, 32'd0, 1'b0);
        repeat ($urandom_range(3, 12)) add_request(ACT_INSERT, $urandom_range(0, plan_len), pick_value(), 1'b0);
      end
      if ($urandom_range(0, 4) == 0) tx_calm = !tx_calm;
      kind = $urandom_range(0, 9);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Sampling on the falling edge keeps this loop clear of the clocked blocks.
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || sent_total != done_total);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d transactions: insert %0d, remove %0d, read %0d, overwrite %0d, find %0d, clear %0d, unused codes %0d",
             sent_total, act_count[0], act_count[1], act_count[2], act_count[3],
             act_count[4], act_count[5], act_count[6] + act_count[7]);
    $display("Range errors %0d, full-list rejections %0d, finds that hit %0d, results checked %0d",
             range_count, full_count, hit_count, done_total);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
